/* design/rcv_pkg.sv */
// Shared types, constants and the quarter-sine builder for the resampling clip voice.
// No dependencies; imported by rcv_ctrl, rcv_dp, resampling_clip_voice and the testbench.
package rcv_pkg;

    localparam int SAMPLE_BITS       = 24;
    localparam int SINE_DEPTH_DFLT   = 256;
    localparam int MAX_OUTPUTS_DFLT  = 16;
    localparam int PHASE_BITS        = 20;
    localparam int PHASE_ACC_BITS    = PHASE_BITS + 1;
    localparam int GAIN_BITS         = 16;
    localparam int LEN_BITS          = 24;
    localparam int CFG_ADDR_BITS     = 3;
    localparam int CFG_DATA_BITS     = 24;
    localparam int MUL_A_BITS        = 33;
    localparam int MUL_B_BITS        = 19;
    localparam int MUL_P_BITS        = MUL_A_BITS + MUL_B_BITS;

    localparam logic [PHASE_ACC_BITS-1:0] PHASE_ONE = PHASE_ACC_BITS'(65536);
    localparam logic [15:0]               UNITY_Q15 = 16'd32768;

    // Register reset values
    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST = PHASE_BITS'(65536);
    localparam logic [GAIN_BITS-1:0]  CLIP_GAIN_RST  = 16'd16384;
    localparam logic [GAIN_BITS-1:0]  PAN_GAIN_RST   = 16'd23170;
    localparam logic [LEN_BITS-1:0]   FADE_LEN_RST   = 24'd120;
    localparam logic [LEN_BITS-1:0]   CLIP_LEN_RST   = 24'd48000;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_PHASE_STEP,
        REG_CLIP_GAIN,
        REG_LEFT_PAN,
        REG_RIGHT_PAN,
        REG_FADE_IN,
        REG_FADE_OUT,
        REG_CLIP_LEN
    } rcv_reg_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_DIV, ST_FADE, ST_GAIN, ST_PANL, ST_PANR,
        ST_IPL0, ST_IPL1, ST_IPR0, ST_IPR1, ST_SCL, ST_SCR, ST_EMIT, ST_FINISH
    } rcv_state_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DIV_INIT, OP_DIV_STEP, OP_FADE, OP_GAIN, OP_PANL,
        OP_PANR, OP_IPL0, OP_IPL1, OP_IPR0, OP_IPR1, OP_SCL, OP_SCR, OP_EMIT,
        OP_FINISH
    } rcv_op_t;

    typedef struct packed {
        rcv_op_t op;
    } rcv_cmd_t;

    typedef struct packed {
        logic more;      // another output is due for the current input
        logic out_free;  // output register can take a result this cycle
    } rcv_status_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] source_left;
        logic signed [SAMPLE_BITS-1:0] source_right;
    } rcv_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic        [SAMPLE_BITS-1:0] peak_level;
        logic                          last;
    } rcv_out_t;

    // Quarter-sine entry i of a table of 2**depth_log2 steps, Q1.15.
    // 9th-order odd series in Horner form, Q30 steps floored, result rounded to Q1.15.
    function automatic logic [15:0] sine_entry(int unsigned i, int unsigned depth_log2);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        longint unsigned d;
        longint unsigned s;
        t  = (64'd1686629713 * 64'(i)) >> depth_log2;
        t2 = (t * t) >> 30;
        a  = 64'd1073741824 - t2 / 72;
        b  = 64'd1073741824 - ((t2 * a) >> 30) / 42;
        c  = 64'd1073741824 - ((t2 * b) >> 30) / 20;
        d  = 64'd1073741824 - ((t2 * c) >> 30) / 6;
        s  = (t * d) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32768)
        begin
            s = 64'd32768;
        end
        return s[15:0];
    endfunction

endpackage

/* design/rcv_ctrl.sv */
// Sequencer for the resampling clip voice: steps the shared datapath per output.
// Depends on rcv_pkg.
module rcv_ctrl #(
    parameter int SINE_TABLE_DEPTH = rcv_pkg::SINE_DEPTH_DFLT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rcv_pkg::rcv_status_t status,
    output rcv_pkg::rcv_cmd_t    cmd
);
    import rcv_pkg::*;

    localparam int QW = $clog2(SINE_TABLE_DEPTH);
    localparam int CW = $clog2(QW);

    rcv_state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // State and divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cnt_next   = '0;
                state_next = status.more ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                begin
                    state_next = ST_FADE;
                end
            end
            ST_FADE:   state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_PANL;
            ST_PANL:   state_next = ST_PANR;
            ST_PANR:   state_next = ST_IPL0;
            ST_IPL0:   state_next = ST_IPL1;
            ST_IPL1:   state_next = ST_IPR0;
            ST_IPR0:   state_next = ST_IPR1;
            ST_IPR1:   state_next = ST_SCL;
            ST_SCL:    state_next = ST_SCR;
            ST_SCR:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_LOAD : OP_NONE;
            end
            ST_CHECK:  cmd.op = status.more ? OP_DIV_INIT : OP_NONE;
            ST_DIV:    cmd.op = OP_DIV_STEP;
            ST_FADE:   cmd.op = OP_FADE;
            ST_GAIN:   cmd.op = OP_GAIN;
            ST_PANL:   cmd.op = OP_PANL;
            ST_PANR:   cmd.op = OP_PANR;
            ST_IPL0:   cmd.op = OP_IPL0;
            ST_IPL1:   cmd.op = OP_IPL1;
            ST_IPR0:   cmd.op = OP_IPR0;
            ST_IPR1:   cmd.op = OP_IPR1;
            ST_SCL:    cmd.op = OP_SCL;
            ST_SCR:    cmd.op = OP_SCR;
            ST_EMIT:   cmd.op = status.out_free ? OP_EMIT : OP_NONE;
            ST_FINISH: cmd.op = OP_FINISH;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

/* design/rcv_dp.sv */
// Datapath of the resampling clip voice: config, state, fade dividers, sine table,
// shared multiplier and the output register. Depends on rcv_pkg.
module rcv_dp #(
    parameter int SINE_TABLE_DEPTH = rcv_pkg::SINE_DEPTH_DFLT,
    parameter int MAX_OUTPUTS      = rcv_pkg::MAX_OUTPUTS_DFLT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rcv_pkg::rcv_cmd_t                     cmd,
    output rcv_pkg::rcv_status_t                  status,
    input  rcv_pkg::rcv_in_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output rcv_pkg::rcv_out_t                     out_data,
    input  logic                                  cfg_we,
    input  logic [rcv_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [rcv_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
    import rcv_pkg::*;

    localparam int QW = $clog2(SINE_TABLE_DEPTH);
    localparam int IW = QW + 1;
    localparam int NW = $clog2(MAX_OUTPUTS + 1);
    localparam int SB = SAMPLE_BITS;

    // Configuration registers
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [GAIN_BITS-1:0]  clip_gain_reg, lpan_reg, rpan_reg;
    logic [LEN_BITS-1:0]   fin_len_reg, fout_len_reg, clip_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RST;
            clip_gain_reg  <= CLIP_GAIN_RST;
            lpan_reg       <= PAN_GAIN_RST;
            rpan_reg       <= PAN_GAIN_RST;
            fin_len_reg    <= FADE_LEN_RST;
            fout_len_reg   <= FADE_LEN_RST;
            clip_len_reg   <= CLIP_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (rcv_reg_t'(cfg_addr))
                REG_PHASE_STEP: phase_step_reg <= cfg_wdata[PHASE_BITS-1:0];
                REG_CLIP_GAIN:  clip_gain_reg  <= cfg_wdata[GAIN_BITS-1:0];
                REG_LEFT_PAN:   lpan_reg       <= cfg_wdata[GAIN_BITS-1:0];
                REG_RIGHT_PAN:  rpan_reg       <= cfg_wdata[GAIN_BITS-1:0];
                REG_FADE_IN:    fin_len_reg    <= cfg_wdata[LEN_BITS-1:0];
                REG_FADE_OUT:   fout_len_reg   <= cfg_wdata[LEN_BITS-1:0];
                REG_CLIP_LEN:   clip_len_reg   <= cfg_wdata[LEN_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Quarter-sine table, constant logic
    logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];
    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++)
    begin : g_sine
        assign sine_rom[gi] = sine_entry(gi, QW);
    end

    // Voice state; the read phase has one spare bit so a step past 1.0 never wraps
    logic signed [SB-1:0]      prev_l_reg, prev_r_reg, cur_l_reg, cur_r_reg;
    logic [PHASE_ACC_BITS-1:0] phase_reg;
    logic [LEN_BITS-1:0]       count_reg;
    logic [SB-1:0]             peak_reg;
    logic [NW-1:0]             n_reg;

    // Fade index dividers (one quotient bit per step)
    logic [LEN_BITS-1:0] rem_in_reg, rem_out_reg;
    logic [QW-1:0]       q_in_reg, q_out_reg;
    logic                sat_in_reg, sat_out_reg, off_in_reg, off_out_reg;

    // Product registers
    logic [15:0]              fade_reg;
    logic [31:0]              g_reg;
    logic [17:0]              gl_reg, gr_reg;
    logic signed [MUL_P_BITS-1:0] acc_reg;
    logic signed [SB-1:0]     il_reg, ir_reg, res_l_reg, res_r_reg;

    rcv_out_t out_reg;
    logic     out_valid_reg;

    // Divider step helpers
    logic [LEN_BITS:0]   rem2_in, rem2_out;
    logic                ge_in, ge_out;
    logic [LEN_BITS-1:0] num_out;

    assign rem2_in  = {rem_in_reg, 1'b0};
    assign rem2_out = {rem_out_reg, 1'b0};
    assign ge_in    = rem2_in  >= {1'b0, fin_len_reg};
    assign ge_out   = rem2_out >= {1'b0, fout_len_reg};
    assign num_out  = clip_len_reg - count_reg;

    // Table reads
    logic [IW-1:0] idx_in, idx_out;
    logic [15:0]   fin_val, fout_val;

    assign idx_in   = sat_in_reg  ? IW'(SINE_TABLE_DEPTH) : {1'b0, q_in_reg};
    assign idx_out  = sat_out_reg ? IW'(SINE_TABLE_DEPTH) : {1'b0, q_out_reg};
    assign fin_val  = off_in_reg  ? UNITY_Q15 : sine_rom[idx_in];
    assign fout_val = off_out_reg ? UNITY_Q15 : sine_rom[idx_out];

    // Shared multiplier operand select
    logic [15:0]                  frac;
    logic [16:0]                  wgt;
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic signed [MUL_P_BITS-1:0] prod;

    assign frac = phase_reg[15:0];
    assign wgt  = 17'h10000 - {1'b0, frac};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_FADE:
            begin
                mul_a = {17'd0, fin_val};
                mul_b = {3'd0, fout_val};
            end
            OP_GAIN:
            begin
                mul_a = {17'd0, clip_gain_reg};
                mul_b = {3'd0, fade_reg};
            end
            OP_PANL:
            begin
                mul_a = {1'b0, g_reg};
                mul_b = {3'd0, lpan_reg};
            end
            OP_PANR:
            begin
                mul_a = {1'b0, g_reg};
                mul_b = {3'd0, rpan_reg};
            end
            OP_IPL0:
            begin
                mul_a = MUL_A_BITS'(prev_l_reg);
                mul_b = {2'd0, wgt};
            end
            OP_IPL1:
            begin
                mul_a = MUL_A_BITS'(cur_l_reg);
                mul_b = {3'd0, frac};
            end
            OP_IPR0:
            begin
                mul_a = MUL_A_BITS'(prev_r_reg);
                mul_b = {2'd0, wgt};
            end
            OP_IPR1:
            begin
                mul_a = MUL_A_BITS'(cur_r_reg);
                mul_b = {3'd0, frac};
            end
            OP_SCL:
            begin
                mul_a = MUL_A_BITS'(il_reg);
                mul_b = {1'b0, gl_reg};
            end
            OP_SCR:
            begin
                mul_a = MUL_A_BITS'(ir_reg);
                mul_b = {1'b0, gr_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Rounding and saturation of the product
    logic signed [MUL_P_BITS-1:0] rnd14, rnd28, isum;
    logic signed [MUL_P_BITS-16:0] scl;
    logic signed [SB-1:0]          scl_sat;

    assign rnd14 = prod + MUL_P_BITS'(16384);
    assign rnd28 = prod + MUL_P_BITS'(268435456);
    assign isum  = acc_reg + prod;
    assign scl   = rnd14[MUL_P_BITS-1:15];

    always_comb
    begin
        if (scl[MUL_P_BITS-16] == 1'b0 && scl[MUL_P_BITS-16:SB-1] != '0)
        begin
            scl_sat = {1'b0, {(SB-1){1'b1}}};
        end
        else if (scl[MUL_P_BITS-16] == 1'b1 && scl[MUL_P_BITS-16:SB-1] != '1)
        begin
            scl_sat = {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            scl_sat = scl[SB-1:0];
        end
    end

    // Loop condition now and after the output being emitted
    logic [PHASE_ACC_BITS-1:0] ph_sum;
    logic [NW-1:0]             n_inc;
    logic [LEN_BITS-1:0]       count_inc;
    logic                      more_next;

    assign ph_sum    = phase_reg + {1'b0, phase_step_reg};
    assign n_inc     = n_reg + 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign more_next = (ph_sum < PHASE_ONE) && (n_inc < NW'(MAX_OUTPUTS))
                       && (count_inc < clip_len_reg);

    assign status.more     = (phase_reg < PHASE_ONE) && (n_reg < NW'(MAX_OUTPUTS))
                             && (count_reg < clip_len_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    // Peak tracking
    logic [SB-1:0] mag_l, mag_r, pk, peak_new;

    assign mag_l    = res_l_reg[SB-1] ? (~res_l_reg + 1'b1) : res_l_reg;
    assign mag_r    = res_r_reg[SB-1] ? (~res_r_reg + 1'b1) : res_r_reg;
    assign pk       = (mag_l > mag_r) ? mag_l : mag_r;
    assign peak_new = (pk > peak_reg) ? pk : peak_reg;

    // Control state of the voice
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            phase_reg     <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    n_reg <= '0;
                end
                OP_EMIT:
                begin
                    phase_reg <= ph_sum;
                    n_reg     <= n_inc;
                    count_reg <= count_inc;
                    peak_reg  <= peak_new;
                end
                OP_FINISH:
                begin
                    phase_reg  <= (phase_reg >= PHASE_ONE) ? (phase_reg - PHASE_ONE) : '0;
                    prev_l_reg <= cur_l_reg;
                    prev_r_reg <= cur_r_reg;
                end
                default: ;
            endcase
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                cur_l_reg <= in_data.source_left;
                cur_r_reg <= in_data.source_right;
            end
            OP_DIV_INIT:
            begin
                rem_in_reg  <= count_reg;
                rem_out_reg <= num_out;
                q_in_reg    <= '0;
                q_out_reg   <= '0;
                sat_in_reg  <= count_reg >= fin_len_reg;
                sat_out_reg <= num_out >= fout_len_reg;
                off_in_reg  <= fin_len_reg == '0;
                off_out_reg <= fout_len_reg == '0;
            end
            OP_DIV_STEP:
            begin
                rem_in_reg  <= ge_in ? LEN_BITS'(rem2_in - {1'b0, fin_len_reg})
                                     : rem2_in[LEN_BITS-1:0];
                rem_out_reg <= ge_out ? LEN_BITS'(rem2_out - {1'b0, fout_len_reg})
                                      : rem2_out[LEN_BITS-1:0];
                q_in_reg    <= {q_in_reg[QW-2:0], ge_in};
                q_out_reg   <= {q_out_reg[QW-2:0], ge_out};
            end
            OP_FADE: fade_reg  <= rnd14[30:15];
            OP_GAIN: g_reg     <= prod[31:0];
            OP_PANL: gl_reg    <= rnd28[46:29];
            OP_PANR: gr_reg    <= rnd28[46:29];
            OP_IPL0: acc_reg   <= prod;
            OP_IPL1: il_reg    <= isum[SB+15:16];
            OP_IPR0: acc_reg   <= prod;
            OP_IPR1: ir_reg    <= isum[SB+15:16];
            OP_SCL:  res_l_reg <= scl_sat;
            OP_SCR:  res_r_reg <= scl_sat;
            OP_EMIT:
            begin
                out_reg.out_left   <= res_l_reg;
                out_reg.out_right  <= res_r_reg;
                out_reg.peak_level <= peak_new;
                out_reg.last       <= !more_next;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* design/resampling_clip_voice.sv */
// Top level of the resampling clip voice: controller plus datapath.
// Depends on rcv_pkg, rcv_ctrl and rcv_dp.
//
//   Channel   Signals                          Moves
//   in        in_valid / in_ready / in_data    one stereo source pair per transfer
//   out       out_valid / out_ready / out_data one processed pair, peak, last flag
//   cfg       cfg_we / cfg_addr / cfg_wdata    one register write per cycle
//
// For each output the sequencer runs a check state, then one quotient bit per cycle
// for the two fade dividers, then ten passes through the single shared multiplier,
// then the emit state, which waits while the output register holds an untaken result.
// Once no output is due, a finish state returns it to idle for the next transfer.
// in_ready is high only while the sequencer is idle; a held result does not
// block the next input, only the next output. Reset is asynchronous, active low.
module resampling_clip_voice #(
    parameter int SINE_TABLE_DEPTH = rcv_pkg::SINE_DEPTH_DFLT,
    parameter int MAX_OUTPUTS      = rcv_pkg::MAX_OUTPUTS_DFLT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rcv_pkg::rcv_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rcv_pkg::rcv_out_t                 out_data,
    input  logic                              cfg_we,
    input  logic [rcv_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [rcv_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
    import rcv_pkg::*;

    rcv_cmd_t    cmd;
    rcv_status_t status;

    rcv_ctrl #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rcv_dp #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .MAX_OUTPUTS     (MAX_OUTPUTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Magnitudes for the peak check
    logic [SAMPLE_BITS-1:0] chk_mag_l, chk_mag_r;

    assign chk_mag_l = out_data.out_left[SAMPLE_BITS-1]
                       ? (~out_data.out_left + 1'b1) : out_data.out_left;
    assign chk_mag_r = out_data.out_right[SAMPLE_BITS-1]
                       ? (~out_data.out_right + 1'b1) : out_data.out_right;

    // A held non-final result means the item is still in work
    a_idle_only_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_data.last))
        else $error("input accepted while results of an item are pending");

    // Reported peak covers the pair it travels with
    a_peak_covers_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.peak_level >= chk_mag_l && out_data.peak_level >= chk_mag_r))
        else $error("peak level below output magnitude");

    // Peak never falls between consecutive transfers
    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && $past(out_valid && out_ready) && $past(rst_n))
        |-> out_data.peak_level >= $past(out_data.peak_level))
        else $error("peak level decreased");

endmodule

/* tb/sv/resampling_clip_voice_tb.sv */
// Testbench for the resampling clip voice: directed and random stereo source transfers, checked
// against an in-bench interpolation, fade, pan and peak predictor. Depends on rcv_pkg and resampling_clip_voice.
`timescale 1ns / 100ps
module resampling_clip_voice_tb;
    import rcv_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int OUT_CAP     = 16;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    rcv_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rcv_out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    resampling_clip_voice dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    // Predictor copy of the registers and voice state
    longint unsigned step_q16, gain_q14, pan_l, pan_r, fin_len, fout_len, clip_length;
    longint signed   last_l, last_r;
    longint unsigned phase_acc, emitted, peak_max;
    logic [15:0]     quarter_sine [0:TABLE_DEPTH];

    rcv_in_t  source_queue [$];
    rcv_out_t expected_outputs [$];
    int       error_count = 0;
    longint   cycle_count = 0;
    bit       driver_hold = 1'b0;
    bit       in_seen = 1'b0;
    int       burst_left = 0;
    int       gap_left = 0;

    // Quarter-sine table, built independently in Q30 Horner form
    function automatic logic [15:0] sine_q15(longint unsigned i);
        longint unsigned t, t2, a, b, c, d, s;
        t  = (64'd1686629713 * i) / TABLE_DEPTH;
        t2 = (t * t) >> 30;
        a  = 64'd1073741824 - t2 / 72;
        b  = 64'd1073741824 - ((t2 * a) >> 30) / 42;
        c  = 64'd1073741824 - ((t2 * b) >> 30) / 20;
        d  = 64'd1073741824 - ((t2 * c) >> 30) / 6;
        s  = ((t * d) >> 30 + 0);
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32768)
        begin
            s = 64'd32768;
        end
        return s[15:0];
    endfunction

    function automatic longint unsigned fade_gain(longint unsigned num, longint unsigned len);
        longint unsigned idx;
        if (len == 0)
        begin
            return 32768;
        end
        idx = (num * TABLE_DEPTH) / len;
        if (idx > TABLE_DEPTH)
        begin
            idx = TABLE_DEPTH;
        end
        return quarter_sine[idx];
    endfunction

    function automatic longint signed lerp(longint signed a, longint signed b,
                                            longint unsigned f);
        longint signed sum;
        sum = a * longint'(65536 - f) + b * longint'(f);
        return sum >>> 16;
    endfunction

    function automatic longint signed apply_gain(longint signed x, longint unsigned g);
        longint signed p;
        p = (x * longint'(g) + 16384) >>> 15;
        if (p > 8388607)
        begin
            p = 8388607;
        end
        if (p < -8388608)
        begin
            p = -8388608;
        end
        return p;
    endfunction

    // Work out the outputs of one accepted source pair
    task automatic predict_resample(rcv_in_t src);
        longint signed cur_l, cur_r, l, r;
        longint unsigned ph, fade, g, gl, gr, pk;
        int n;
        rcv_out_t res;
        cur_l = src.source_left;
        cur_r = src.source_right;
        ph = phase_acc;
        n = 0;
        while (ph < 65536 && n < OUT_CAP && emitted < clip_length)
        begin
            fade = (fade_gain(emitted, fin_len) * fade_gain(clip_length - emitted, fout_len)
                    + 16384) >> 15;
            g  = gain_q14 * fade;
            gl = (g * pan_l + (64'd1 << 28)) >> 29;
            gr = (g * pan_r + (64'd1 << 28)) >> 29;
            l  = apply_gain(lerp(last_l, cur_l, ph), gl);
            r  = apply_gain(lerp(last_r, cur_r, ph), gr);
            pk = (l < 0) ? -l : l;
            if (((r < 0) ? -r : r) > pk)
            begin
                pk = (r < 0) ? -r : r;
            end
            if (pk > peak_max)
            begin
                peak_max = pk;
            end
            res.out_left   = l[SAMPLE_BITS-1:0];
            res.out_right  = r[SAMPLE_BITS-1:0];
            res.peak_level = peak_max[SAMPLE_BITS-1:0];
            res.last       = 1'b0;
            expected_outputs = {expected_outputs, res};
            n++;
            emitted++;
            ph += step_q16;
        end
        if (n > 0)
        begin
            expected_outputs[$].last = 1'b1;
        end
        phase_acc = (ph >= 65536) ? ph - 65536 : 0;
        last_l = cur_l;
        last_r = cur_r;
    endtask

    task automatic write_reg(rcv_reg_t idx, longint unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_DATA_BITS-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PHASE_STEP: step_q16    = value & 20'hFFFFF;
            REG_CLIP_GAIN:  gain_q14    = value & 16'hFFFF;
            REG_LEFT_PAN:   pan_l       = value & 16'hFFFF;
            REG_RIGHT_PAN:  pan_r       = value & 16'hFFFF;
            REG_FADE_IN:    fin_len     = value & 24'hFFFFFF;
            REG_FADE_OUT:   fout_len    = value & 24'hFFFFFF;
            REG_CLIP_LEN:   clip_length = value & 24'hFFFFFF;
            default: ;
        endcase
    endtask

    // Let the queued pairs drain, then the block go quiet
    task automatic wait_idle();
        while (source_queue.size() != 0 || in_valid || expected_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
    endtask

    function automatic rcv_in_t rand_pair(int kind);
        rcv_in_t p;
        p.source_left  = SAMPLE_BITS'($urandom());
        p.source_right = (kind == 0) ? p.source_left : SAMPLE_BITS'($urandom());
        return p;
    endfunction

    task automatic enqueue_pair(rcv_in_t p);
        source_queue = {source_queue, p};
    endtask

    task automatic push_pair(logic [23:0] l, logic [23:0] r);
        rcv_in_t p;
        p.source_left  = l;
        p.source_right = r;
        enqueue_pair(p);
    endtask

    // Sender: bursts with random gaps, pairs change at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // a pending pair is held until the rising edge has taken it
            if (!in_valid || in_seen)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (source_queue.size() != 0 && !driver_hold)
                begin
                    in_data  <= source_queue.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            // receiver stall pattern: long ready runs mixed with stalls
            out_ready <= (cycle_count % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // Predict on each accepted source transfer, check each output transfer
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_seen     <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            predict_resample(in_data);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                $error("unexpected output transfer: %p", out_data);
                error_count++;
            end
            else
            begin
                rcv_out_t exp_r;
                exp_r = expected_outputs.pop_front();
                if (out_data.out_left !== exp_r.out_left)
                begin
                    $error("out_left expected %0d got %0d", exp_r.out_left, out_data.out_left);
                    error_count++;
                end
                if (out_data.out_right !== exp_r.out_right)
                begin
                    $error("out_right expected %0d got %0d", exp_r.out_right,
                           out_data.out_right);
                    error_count++;
                end
                if (out_data.peak_level !== exp_r.peak_level)
                begin
                    $error("peak_level expected %0d got %0d", exp_r.peak_level,
                           out_data.peak_level);
                    error_count++;
                end
                if (out_data.last !== exp_r.last)
                begin
                    $error("last expected %0b got %0b", exp_r.last, out_data.last);
                    error_count++;
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int k;
        for (k = 0; k <= TABLE_DEPTH; k++)
        begin
            quarter_sine[k] = sine_q15(k);
        end
        step_q16 = 65536; gain_q14 = 16384; pan_l = 23170; pan_r = 23170;
        fin_len = 120; fout_len = 120; clip_length = 48000;
        last_l = 0; last_r = 0; phase_acc = 0; emitted = 0; peak_max = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes at reset settings
        push_pair(24'h7FFFFF, 24'h800000);
        push_pair(24'h800000, 24'h7FFFFF);
        push_pair(24'h000000, 24'hFFFFFF);
        push_pair(24'h555555, 24'hAAAAAA);
        push_pair(24'hAAAAAA, 24'h555555);
        wait_idle();

        // Fractional step, full gain, saturating products, fades off
        write_reg(REG_PHASE_STEP, 4096);
        write_reg(REG_CLIP_GAIN, 65535);
        write_reg(REG_LEFT_PAN, 32768);
        write_reg(REG_RIGHT_PAN, 0);
        write_reg(REG_FADE_IN, 0);
        write_reg(REG_FADE_OUT, 0);
        push_pair(24'h7FFFFF, 24'h7FFFFF);
        push_pair(24'h800000, 24'h800000);
        push_pair(24'h123456, 24'hEDCBA9);
        wait_idle();

        // Phase step zero, then a large step of 8.0 skipping inputs
        write_reg(REG_PHASE_STEP, 0);
        push_pair(24'h400000, 24'hC00000);
        push_pair(24'h000001, 24'hFFFFFF);
        wait_idle();
        write_reg(REG_PHASE_STEP, 524288);
        for (k = 0; k < 10; k++)
        begin
            enqueue_pair(rand_pair(k % 2));
        end
        wait_idle();

        // Short clip runs out; later inputs give nothing
        write_reg(REG_PHASE_STEP, 30000);
        write_reg(REG_CLIP_GAIN, 0);
        write_reg(REG_CLIP_LEN, emitted + 5);
        for (k = 0; k < 5; k++)
        begin
            enqueue_pair(rand_pair(1));
        end
        wait_idle();

        // Random phase: fresh clip length, fade-in of one sample, fade-out across the clip
        write_reg(REG_CLIP_LEN, 16777215);
        write_reg(REG_FADE_IN, 1);
        write_reg(REG_FADE_OUT, 16777215);
        write_reg(REG_CLIP_GAIN, 20000);
        write_reg(REG_LEFT_PAN, 23170);
        write_reg(REG_RIGHT_PAN, 32768);
        for (k = 0; k < 40; k++)
        begin
            enqueue_pair(rand_pair($urandom_range(0, 3)));
        end
        wait_idle();

        // Clip ending mid-fade with random gains and steps
        write_reg(REG_PHASE_STEP, $urandom_range(20000, 140000));
        write_reg(REG_CLIP_GAIN, $urandom_range(0, 65535));
        write_reg(REG_FADE_IN, $urandom_range(1, 300));
        write_reg(REG_FADE_OUT, $urandom_range(1, 80));
        write_reg(REG_CLIP_LEN, emitted + 150);
        for (k = 0; k < 45; k++)
        begin
            enqueue_pair(rand_pair($urandom_range(0, 3)));
            if (k == 20)
            begin
                // sender waits until all outputs have come
                while (source_queue.size() != 0 || in_valid)
                begin
                    @(posedge clk);
                end
                driver_hold = 1'b1;
                while (expected_outputs.size() != 0)
                begin
                    @(posedge clk);
                end
                driver_hold = 1'b0;
            end
        end
        wait_idle();
        for (k = 0; k < 20; k++)
        begin
            write_reg(REG_PHASE_STEP, $urandom_range(4096, 524288));
            enqueue_pair(rand_pair($urandom_range(0, 3)));
            wait_idle();
        end

        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* files.f */
design/rcv_pkg.sv
design/rcv_ctrl.sv
design/rcv_dp.sv
design/resampling_clip_voice.sv
tb/sv/resampling_clip_voice_tb.sv
